FILE: rtl/core/fisr_pkg.sv
package fisr_pkg;

	// bit-level seed and float constants
	localparam logic [31:0] MAGIC_WORD      = 32'h5f3759df;
	localparam logic [31:0] CANON_NAN       = 32'h7fc00000;
	localparam logic [31:0] FP_HALF         = 32'h3f000000;
	localparam logic [31:0] FP_THREE_HALVES = 32'h3fc00000;

	// side data carried beside each float unit: {y1, y, half}
	localparam int SIDE_W = 96;

	// configuration
	localparam int          ADDR_W        = 3;
	localparam logic [1:0]  STEPS_RESET   = 2'd2;
	localparam logic [1:0]  STEPS_ONE     = 2'd1;
	localparam logic        REG_STEPS_IDX = 1'b0;

endpackage

FILE: rtl/core/fisr_fmul.sv
module fisr_fmul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [31:0]                a,
	input  logic [31:0]                b,
	input  logic [fisr_pkg::SIDE_W-1:0] in_side,
	output logic                       out_valid,
	output logic [31:0]                res,
	output logic [fisr_pkg::SIDE_W-1:0] out_side
);
	import fisr_pkg::*;

	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) n = 6'(47 - i);
		end
		return n;
	endfunction

	// stage 1: specials and mantissa product
	logic [7:0]  ea, eb;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
	logic [23:0] ma, mb;
	logic [7:0]  eaa, ebb;
	logic        spec;
	logic [31:0] spec_res;

	assign ea     = a[30:23];
	assign eb     = b[30:23];
	assign a_nan  = (ea == 8'hff) && (a[22:0] != 23'd0);
	assign b_nan  = (eb == 8'hff) && (b[22:0] != 23'd0);
	assign a_inf  = (ea == 8'hff) && (a[22:0] == 23'd0);
	assign b_inf  = (eb == 8'hff) && (b[22:0] == 23'd0);
	assign a_zero = (ea == 8'h00) && (a[22:0] == 23'd0);
	assign b_zero = (eb == 8'h00) && (b[22:0] == 23'd0);
	assign sgn    = a[31] ^ b[31];
	assign ma     = {ea != 8'h00, a[22:0]};
	assign mb     = {eb != 8'h00, b[22:0]};
	assign eaa    = (ea == 8'h00) ? 8'd1 : ea;
	assign ebb    = (eb == 8'h00) ? 8'd1 : eb;

	always_comb begin
		spec     = 1'b1;
		spec_res = {sgn, 31'd0};
		if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
			spec_res = CANON_NAN;
		end else if (a_inf || b_inf) begin
			spec_res = {sgn, 8'hff, 23'd0};
		end else if (!(a_zero || b_zero)) begin
			spec = 1'b0;
		end
	end

	logic                valid_s1, spec_s1, sgn_s1;
	logic [31:0]         spec_res_s1;
	logic [47:0]         prod_s1;
	logic [8:0]          esum_s1;
	logic [SIDE_W-1:0]   side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1     <= spec;
			spec_res_s1 <= spec_res;
			sgn_s1      <= sgn;
			prod_s1     <= ma * mb;
			esum_s1     <= {1'b0, eaa} + {1'b0, ebb};
			side_s1     <= in_side;
		end
	end

	// stage 2: normalise, denormalise, round
	logic [5:0]         lz;
	logic signed [10:0] e_res;
	logic [47:0]        norm;
	logic [6:0]         sh;
	logic [95:0]        wide;
	logic [7:0]         expf;
	logic [22:0]        mant;
	logic               rbit, sticky, inc;
	logic [30:0]        rounded;
	logic [31:0]        result;

	always_comb begin
		lz    = lzc48(prod_s1);
		e_res = $signed({2'b00, esum_s1}) - 11'sd126 - $signed({5'd0, lz});
		norm  = prod_s1 << lz;
		if (e_res >= 11'sd1) begin
			sh   = 7'd0;
			expf = e_res[7:0];
		end else if (e_res < -11'sd63) begin
			sh   = 7'd64;
			expf = 8'd0;
		end else begin
			sh   = 7'(11'sd1 - e_res);
			expf = 8'd0;
		end
		wide    = {norm, 48'd0} >> sh;
		mant    = wide[94:72];
		rbit    = wide[71];
		sticky  = (|wide[70:48]) | (|wide[47:0]);
		inc     = rbit & (sticky | mant[0]);
		rounded = {expf, mant} + {30'd0, inc};
		if (spec_s1) begin
			result = spec_res_s1;
		end else if (e_res >= 11'sd255) begin
			result = {sgn_s1, 8'hff, 23'd0};
		end else begin
			result = {sgn_s1, rounded};
		end
	end

	logic valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res      <= result;
			out_side <= side_s1;
		end
	end

	assign out_valid = valid_s2;

endmodule

FILE: rtl/core/fisr_fsub.sv
module fisr_fsub (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [31:0]                a,
	input  logic [31:0]                b,
	input  logic [fisr_pkg::SIDE_W-1:0] in_side,
	output logic                       out_valid,
	output logic [31:0]                res,
	output logic [fisr_pkg::SIDE_W-1:0] out_side
);
	import fisr_pkg::*;

	function automatic logic [4:0] lzc28(input logic [27:0] v);
		logic [4:0] n;
		n = 5'd28;
		for (int i = 0; i < 28; i++) begin
			if (v[i]) n = 5'(27 - i);
		end
		return n;
	endfunction

	// stage 1: a - b as a + (-b); swap, align, add
	logic [31:0] bn, big, sml;
	logic        a_nan, b_nan, a_inf, b_inf, eff_sub;
	logic [7:0]  e_l, e_s, d;
	logic [4:0]  dcl;
	logic [23:0] m_l, m_s;
	logic [53:0] aligned;
	logic [26:0] m_sa;
	logic [27:0] sum;
	logic        spec;
	logic [31:0] spec_res;

	assign bn    = {~b[31], b[30:0]};
	assign a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
	assign b_nan = (bn[30:23] == 8'hff) && (bn[22:0] != 23'd0);
	assign a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
	assign b_inf = (bn[30:23] == 8'hff) && (bn[22:0] == 23'd0);

	always_comb begin
		if (bn[30:0] > a[30:0]) begin
			big = bn;
			sml = a;
		end else begin
			big = a;
			sml = bn;
		end
		eff_sub = a[31] ^ bn[31];
		e_l     = (big[30:23] == 8'h00) ? 8'd1 : big[30:23];
		e_s     = (sml[30:23] == 8'h00) ? 8'd1 : sml[30:23];
		m_l     = {big[30:23] != 8'h00, big[22:0]};
		m_s     = {sml[30:23] != 8'h00, sml[22:0]};
		d       = e_l - e_s;
		dcl     = (d > 8'd27) ? 5'd27 : d[4:0];
		aligned = {m_s, 3'b000, 27'd0} >> dcl;
		m_sa    = {aligned[53:28], aligned[27] | (|aligned[26:0])};
		if (eff_sub) begin
			sum = {1'b0, m_l, 3'b000} - {1'b0, m_sa};
		end else begin
			sum = {1'b0, m_l, 3'b000} + {1'b0, m_sa};
		end
		spec     = 1'b1;
		spec_res = CANON_NAN;
		if (a_nan || b_nan || (a_inf && b_inf && eff_sub)) begin
			spec_res = CANON_NAN;
		end else if (a_inf) begin
			spec_res = {a[31], 8'hff, 23'd0};
		end else if (b_inf) begin
			spec_res = {bn[31], 8'hff, 23'd0};
		end else begin
			spec = 1'b0;
		end
	end

	logic              valid_s1, spec_s1, sgn_s1, zsgn_s1;
	logic [31:0]       spec_res_s1;
	logic [27:0]       sum_s1;
	logic [7:0]        e_l_s1;
	logic [SIDE_W-1:0] side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1     <= spec;
			spec_res_s1 <= spec_res;
			sgn_s1      <= big[31];
			zsgn_s1     <= eff_sub ? 1'b0 : a[31];
			sum_s1      <= sum;
			e_l_s1      <= e_l;
			side_s1     <= in_side;
		end
	end

	// stage 2: normalise and round
	logic [4:0]  lz;
	logic [7:0]  lsh;
	logic [8:0]  expf;
	logic [27:0] norm;
	logic [22:0] mant;
	logic        inc;
	logic [30:0] rounded;
	logic [31:0] result;

	always_comb begin
		lz = lzc28(sum_s1);
		if ({3'd0, lz} <= e_l_s1) begin
			lsh  = {3'd0, lz};
			expf = {1'b0, e_l_s1} + 9'd1 - {4'd0, lz};
		end else begin
			lsh  = e_l_s1;
			expf = 9'd0;
		end
		norm    = sum_s1 << lsh;
		mant    = norm[26:4];
		inc     = norm[3] & ((|norm[2:0]) | mant[0]);
		rounded = {expf[7:0], mant} + {30'd0, inc};
		if (spec_s1) begin
			result = spec_res_s1;
		end else if (sum_s1 == 28'd0) begin
			result = {zsgn_s1, 31'd0};
		end else if (expf >= 9'd255) begin
			result = {sgn_s1, 8'hff, 23'd0};
		end else begin
			result = {sgn_s1, rounded};
		end
	end

	logic valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res      <= result;
			out_side <= side_s1;
		end
	end

	assign out_valid = valid_s2;

endmodule

FILE: rtl/core/fast_inverse_square_root.sv
// Throughput: one item per cycle unless a held result stalls the pipe;
// nine float units of two stages each plus an output stage.
// A stall on the result side holds every stage together, nothing is lost or repeated.
// Reset: asynchronous, active low; clears all valid bits and sets newton_steps to 2.
module fast_inverse_square_root (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [31:0]                 value_bits,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [31:0]                 result_bits,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fisr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import fisr_pkg::*;

	// configuration register
	logic [1:0] newton_steps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newton_steps_q <= STEPS_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_STEPS_IDX)) begin
			newton_steps_q <= pwdata[1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_STEPS_IDX) ? {30'd0, newton_steps_q} : 32'd0;

	// global advance: the whole pipe moves unless the result is held
	logic out_valid_q;
	logic en;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// seed word
	logic [31:0] guess;
	assign guess = MAGIC_WORD - {value_bits[31], value_bits[31:1]};

	// half = x * 0.5
	logic              v_h;
	logic [31:0]       r_h;
	logic [SIDE_W-1:0] s_h;

	fisr_fmul u_half (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(in_valid), .a(value_bits), .b(FP_HALF),
		.in_side({32'd0, guess, 32'd0}),
		.out_valid(v_h), .res(r_h), .out_side(s_h)
	);

	// first Newton step
	logic              v_p1, v_q1, v_d1, v_y1;
	logic [31:0]       r_p1, r_q1, r_d1, r_y1;
	logic [SIDE_W-1:0] s_p1, s_q1, s_d1, s_y1;

	fisr_fmul u_p1 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_h), .a(r_h), .b(s_h[63:32]),
		.in_side({32'd0, s_h[63:32], r_h}),
		.out_valid(v_p1), .res(r_p1), .out_side(s_p1)
	);

	fisr_fmul u_q1 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_p1), .a(r_p1), .b(s_p1[63:32]),
		.in_side(s_p1),
		.out_valid(v_q1), .res(r_q1), .out_side(s_q1)
	);

	fisr_fsub u_d1 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_q1), .a(FP_THREE_HALVES), .b(r_q1),
		.in_side(s_q1),
		.out_valid(v_d1), .res(r_d1), .out_side(s_d1)
	);

	fisr_fmul u_y1 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_d1), .a(s_d1[63:32]), .b(r_d1),
		.in_side(s_d1),
		.out_valid(v_y1), .res(r_y1), .out_side(s_y1)
	);

	// second Newton step, first result kept in the side word
	logic              v_p2, v_q2, v_d2, v_y2;
	logic [31:0]       r_p2, r_q2, r_d2, r_y2;
	logic [SIDE_W-1:0] s_p2, s_q2, s_d2, s_y2;

	fisr_fmul u_p2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_y1), .a(s_y1[31:0]), .b(r_y1),
		.in_side({r_y1, r_y1, s_y1[31:0]}),
		.out_valid(v_p2), .res(r_p2), .out_side(s_p2)
	);

	fisr_fmul u_q2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_p2), .a(r_p2), .b(s_p2[63:32]),
		.in_side(s_p2),
		.out_valid(v_q2), .res(r_q2), .out_side(s_q2)
	);

	fisr_fsub u_d2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_q2), .a(FP_THREE_HALVES), .b(r_q2),
		.in_side(s_q2),
		.out_valid(v_d2), .res(r_d2), .out_side(s_d2)
	);

	fisr_fmul u_y2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_d2), .a(s_d2[63:32]), .b(r_d2),
		.in_side(s_d2),
		.out_valid(v_y2), .res(r_y2), .out_side(s_y2)
	);

	// step count select and NaN canonicalisation
	logic [31:0] pick, final_bits;

	always_comb begin
		pick = (newton_steps_q == STEPS_ONE) ? s_y2[95:64] : r_y2;
		if ((pick[30:23] == 8'hff) && (pick[22:0] != 23'd0)) begin
			final_bits = CANON_NAN;
		end else begin
			final_bits = pick;
		end
	end

	// output register
	logic [31:0] result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_y2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= final_bits;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_bits = result_q;

endmodule
